FILE: hdl/cclsplit_pkg.sv
// cclsplit_pkg: item types, register indexes and byte class table for the
// character class filter and line splitter
// no dependencies
`default_nettype none

package cclsplit_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_CASE_MODE     = 2'd0,
    CFG_FILTER_ENABLE = 2'd1,
    CFG_MAX_LEN       = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  // case modes
  typedef enum logic [1:0] {
    CASE_KEEP  = 2'd0,
    CASE_UPPER = 2'd1,
    CASE_LOWER = 2'd2,
    CASE_NONE  = 2'd3
  } case_mode_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_CUT     = 2'd2,
    KIND_EOS     = 2'd3
  } kind_e;

  localparam logic [7:0]  NUL_BYTE      = 8'h00;
  localparam logic [7:0]  NEWLINE_BYTE  = 8'h0A;
  localparam logic [15:0] MAX_LEN_RESET = 16'd255;
  localparam int unsigned CFG_DATA_W    = 16;

  // class bit positions
  localparam int unsigned CLS_ALNUM = 0;
  localparam int unsigned CLS_ALPHA = 1;
  localparam int unsigned CLS_CNTRL = 2;
  localparam int unsigned CLS_DIGIT = 3;
  localparam int unsigned CLS_PUNCT = 4;
  localparam int unsigned CLS_SPACE = 5;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       partial_line;
  } out_item_t;

  // c-locale ascii classes, bytes 128 and up belong to none
  function automatic logic [5:0] class_bits(input logic [7:0] b);
    logic [5:0] m;
    m = '0;
    if (b < 8'd128) begin
      if (b < 8'd32 || b == 8'd127) m[CLS_CNTRL] = 1'b1;
      if ((b >= 8'd9 && b <= 8'd13) || b == 8'd32) m[CLS_SPACE] = 1'b1;
      if (b >= 8'd48 && b <= 8'd57) begin
        m[CLS_DIGIT] = 1'b1;
        m[CLS_ALNUM] = 1'b1;
      end
      if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) begin
        m[CLS_ALPHA] = 1'b1;
        m[CLS_ALNUM] = 1'b1;
      end
      if ((b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
          (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126))
        m[CLS_PUNCT] = 1'b1;
    end
    return m;
  endfunction

  // upper or lower case conversion of ascii letters
  function automatic logic [7:0] change_case(input case_mode_e mode, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (mode == CASE_UPPER && b >= 8'd97 && b <= 8'd122) r[5] = 1'b0;
    if (mode == CASE_LOWER && b >= 8'd65 && b <= 8'd90) r[5] = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/char_class_filter_line_splitter_top.sv
// char_class_filter_line_splitter_top: filters a byte stream by character
// class, converts case and splits it into lines
// depends on cclsplit_pkg
//
//   channel   signals                                 direction
//   in        in_valid_i, in_ready_o, in_item_i       byte or end of stream in
//   out       out_valid_o, out_ready_i, out_item_o    one result item out
//   cfg       cfg_valid_i, cfg_ready_o, cfg_index_i,  register write in
//             cfg_data_i
//
// one item per cycle sustained while the output is not stalled; an input
// register feeds the result register, so each result passes both registers
// a dropped byte produces no result but still advances the line state
// a stalled output holds the input register; a new item is taken when it frees
// reset clears configuration to its defaults and closes any open line
// configuration writes are taken in every cycle
`default_nettype none

module char_class_filter_line_splitter_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  cclsplit_pkg::in_item_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output cclsplit_pkg::out_item_t               out_item_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [1:0]                            cfg_index_i,
  input  wire  [cclsplit_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cclsplit_pkg::*;

  // configuration registers
  case_mode_e  case_mode_q;
  logic [5:0]  filter_enable_q;
  logic [15:0] max_len_q;

  // input stage, line state and result register
  in_item_t    in_q;
  logic        in_valid_q;
  logic [15:0] kept_count_q, kept_count_d;
  logic        line_open_q, line_open_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic        has_result;
  logic        advance;

  logic [15:0] count_eff;
  logic        keep;

  assign cfg_ready_o = 1'b1;

  // input stage moves on when the result register is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // result and next line state for the item in the input stage
  always_comb begin
    count_eff    = line_open_q ? kept_count_q : 16'd0;
    keep         = (filter_enable_q == 6'd0) ||
                   ((class_bits(in_q.char_in) & filter_enable_q) != 6'd0);
    out_d        = '{kind: KIND_CHAR, data: 8'h00, partial_line: 1'b0};
    has_result   = 1'b1;
    line_open_d  = 1'b0;
    kept_count_d = 16'd0;
    if (in_q.end_of_stream) begin
      out_d.kind         = KIND_EOS;
      out_d.partial_line = line_open_q;
    end else if (in_q.char_in == NEWLINE_BYTE) begin
      out_d.kind = KIND_NEWLINE;
      out_d.data = NEWLINE_BYTE;
    end else if (count_eff >= max_len_q) begin
      out_d.kind = KIND_CUT;
      out_d.data = in_q.char_in;
    end else if (keep && in_q.char_in != NUL_BYTE) begin
      out_d.data   = change_case(case_mode_q, in_q.char_in);
      line_open_d  = 1'b1;
      kept_count_d = count_eff + 16'd1;
    end else begin
      has_result   = 1'b0;
      line_open_d  = 1'b1;
      kept_count_d = count_eff;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_mode_q     <= CASE_KEEP;
      filter_enable_q <= 6'd0;
      max_len_q       <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CASE_MODE:     case_mode_q     <= case_mode_e'(cfg_data_i[1:0]);
        CFG_FILTER_ENABLE: filter_enable_q <= cfg_data_i[5:0];
        CFG_MAX_LEN:       max_len_q       <= cfg_data_i[15:0];
        default:           ;
      endcase
    end
  end

  // control state: stage valids and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      line_open_q  <= 1'b0;
      kept_count_q <= 16'd0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        line_open_q  <= line_open_d;
        kept_count_q <= kept_count_d;
      end
      if (advance) begin
        out_valid_q <= has_result;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_item_i;
    if (advance && has_result) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/cclsplit_checker.sv
// cclsplit_checker: port-level assertions for the line splitter, bound to the
// top level
// depends on cclsplit_pkg and char_class_filter_line_splitter_top
`default_nettype none

module cclsplit_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_o,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input cclsplit_pkg::out_item_t   out_item_o
);
  import cclsplit_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // partial line flag only on end of stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.partial_line |-> out_item_o.kind == KIND_EOS)
    else $error("partial line flag on a non end of stream result");

  // newline end always carries the newline byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_NEWLINE |-> out_item_o.data == NEWLINE_BYTE)
    else $error("newline end with wrong data");

  // end of stream result carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_EOS |-> out_item_o.data == 8'h00)
    else $error("end of stream with nonzero data");

  // no result appears without an earlier accepted item or a taken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2) ||
      $past(in_valid_i && in_ready_o, 3) || $past(out_valid_o && out_ready_i, 1))
    else $error("result without an accepted item");

endmodule

bind char_class_filter_line_splitter_top cclsplit_checker u_cclsplit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
